@@ hw/rtl/rti_pkg.sv @@
// shared types and constants for the ray/triangle intersection unit
// no dependencies; imported by every module of the block
package rti_pkg;

    localparam int COORD_BITS_DEF = 21;
    localparam int FRAC_BITS_DEF  = 10;

    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL   = 3'd3;

    // projection plane picked from the dominant normal axis
    typedef enum logic [1:0] {
        PLANE_XY,
        PLANE_XZ,
        PLANE_YZ
    } plane_t;

    // per-stage control that travels with each item
    typedef struct packed {
        logic valid;
        logic reject;
        logic closer;
    } rti_flags_t;

endpackage

@@ hw/rtl/rti_cfg.sv @@
// triangle configuration registers and values derived from them
// (projection plane, edge vectors, projected area); uses rti_pkg
module rti_cfg #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [3*COORD_BITS-1:0]            vert_a,
    output logic [3*COORD_BITS-1:0]            normal,
    output rti_pkg::plane_t                    plane,
    output logic signed [COORD_BITS-1:0]       vaa,
    output logic signed [COORD_BITS-1:0]       vab,
    output logic signed [COORD_BITS:0]         u1,
    output logic signed [COORD_BITS:0]         u2,
    output logic signed [COORD_BITS:0]         v1,
    output logic signed [COORD_BITS:0]         v2,
    output logic signed [2*COORD_BITS+2:0]     den
);
    import rti_pkg::*;

    localparam int C = COORD_BITS;

    logic [3*C-1:0] va_reg, vb_reg, vc_reg, n_reg;
    logic [C-1:0] ax, ay, az;
    plane_t plane_next, plane_reg;
    logic [1:0] sel_a, sel_b;
    logic [C-1:0] va_a, va_b, vb_a, vb_b, vc_a, vc_b;
    logic signed [C-1:0] vaa_reg, vab_reg;
    logic signed [C:0] u1_reg, u2_reg, v1_reg, v2_reg;
    logic signed [2*C+1:0] m1_reg, m2_reg;
    logic signed [2*C+2:0] den_reg;

    function automatic logic [C-1:0] pick(input logic [3*C-1:0] v, input logic [1:0] i);
        return v[i*C +: C];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
            vb_reg <= '0;
            vc_reg <= '0;
            n_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VERTEX_A: va_reg <= cfg_data[3*C-1:0];
                REG_VERTEX_B: vb_reg <= cfg_data[3*C-1:0];
                REG_VERTEX_C: vc_reg <= cfg_data[3*C-1:0];
                REG_NORMAL:   n_reg  <= cfg_data[3*C-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ax = n_reg[C-1]     ? ~n_reg[C-1:0]     + 1'b1 : n_reg[C-1:0];
        ay = n_reg[2*C-1]   ? ~n_reg[2*C-1:C]   + 1'b1 : n_reg[2*C-1:C];
        az = n_reg[3*C-1]   ? ~n_reg[3*C-1:2*C] + 1'b1 : n_reg[3*C-1:2*C];
        if (ax > ay) begin
            plane_next = (ax > az) ? PLANE_YZ : PLANE_XY;
        end else begin
            plane_next = (ay > az) ? PLANE_XZ : PLANE_XY;
        end
        unique case (plane_next)
            PLANE_XZ: begin
                sel_a = 2'd0;
                sel_b = 2'd2;
            end
            PLANE_YZ: begin
                sel_a = 2'd1;
                sel_b = 2'd2;
            end
            default: begin
                sel_a = 2'd0;
                sel_b = 2'd1;
            end
        endcase
        va_a = pick(va_reg, sel_a);
        va_b = pick(va_reg, sel_b);
        vb_a = pick(vb_reg, sel_a);
        vb_b = pick(vb_reg, sel_b);
        vc_a = pick(vc_reg, sel_a);
        vc_b = pick(vc_reg, sel_b);
    end

    // derived values are registered in turn: plane and edge differences, then the two cross products, then den
    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
        vaa_reg   <= $signed(va_a);
        vab_reg   <= $signed(va_b);
        u1_reg    <= $signed({vb_a[C-1], vb_a}) - $signed({va_a[C-1], va_a});
        u2_reg    <= $signed({vc_a[C-1], vc_a}) - $signed({va_a[C-1], va_a});
        v1_reg    <= $signed({vb_b[C-1], vb_b}) - $signed({va_b[C-1], va_b});
        v2_reg    <= $signed({vc_b[C-1], vc_b}) - $signed({va_b[C-1], va_b});
        m1_reg    <= u1_reg * v2_reg;
        m2_reg    <= v1_reg * u2_reg;
        den_reg   <= (2*C+3)'(m1_reg) - (2*C+3)'(m2_reg);
    end

    assign vert_a = va_reg;
    assign normal = n_reg;
    assign plane  = plane_reg;
    assign vaa    = vaa_reg;
    assign vab    = vab_reg;
    assign u1     = u1_reg;
    assign u2     = u2_reg;
    assign v1     = v1_reg;
    assign v2     = v2_reg;
    assign den    = den_reg;

endmodule

@@ hw/rtl/rti_front.sv @@
// front pipeline: plane dot products, facing and origin tests,
// best-distance cull and divide overflow check; uses rti_pkg
module rti_front #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF,
    localparam int D   = COORD_BITS - 1,
    localparam int NGW = 2*COORD_BITS + 1,
    localparam int LW  = 2*COORD_BITS + 2 + FRAC_BITS,
    localparam int RW  = (LW > NGW + D) ? LW : NGW + D
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3*COORD_BITS-1:0]   in_origin,
    input  logic [3*COORD_BITS-1:0]   in_dir,
    input  logic [D-1:0]              in_best,
    input  logic                      in_best_valid,
    input  logic [3*COORD_BITS-1:0]   vert_a,
    input  logic [3*COORD_BITS-1:0]   normal,
    output rti_pkg::rti_flags_t       out_flags,
    output logic [RW-1:0]             out_rem,
    output logic [NGW-1:0]            out_ng,
    output logic                      out_ovf,
    output logic [3*COORD_BITS-1:0]   out_origin,
    output logic [3*COORD_BITS-1:0]   out_dir
);
    import rti_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PRW = 2*C;
    localparam int GW  = 2*C + 2;
    localparam int TW  = 2*C + 3;
    localparam int NTW = 2*C + 2;
    localparam int NLO = NGW / 2;
    localparam int NHI = NGW - NLO;

    rti_flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic signed [PRW-1:0] nd_reg [3];
    logic signed [PRW-1:0] nv_reg [3];
    logic signed [PRW-1:0] no_reg [3];
    logic [3*C-1:0] o1_reg, o2_reg, o3_reg, o4_reg, o5_reg;
    logic [3*C-1:0] d1_reg, d2_reg, d3_reg, d4_reg, d5_reg;
    logic [D-1:0] best1_reg, best2_reg, best3_reg;
    logic bv1_reg, bv2_reg, bv3_reg, bv4_reg;
    logic signed [GW-1:0] g_reg;
    logic signed [TW-1:0] tn_reg;
    logic [NGW-1:0] ng3_reg, ng4_reg, ng5_reg;
    logic [LW-1:0] lhs3_reg, lhs4_reg;
    logic [NGW+D-1:0] rhs4_reg;
    logic ovf4_reg, ovf5_reg;
    logic [RW-1:0] rem5_reg;

    logic signed [GW-1:0] g_next, ng_full;
    logic signed [TW-1:0] tn_next, nt_full;
    logic reject3_next;
    logic [RW-1:0] lhs_ext, rhs_ext, ngsh_ext;
    logic [NHI+D-1:0] rhs_hi;
    logic [NLO+D-1:0] rhs_lo;

    always_comb begin
        g_next  = GW'(nd_reg[0]) + GW'(nd_reg[1]) + GW'(nd_reg[2]);
        tn_next = TW'(nv_reg[0]) + TW'(nv_reg[1]) + TW'(nv_reg[2])
                - TW'(no_reg[0]) - TW'(no_reg[1]) - TW'(no_reg[2]);
        ng_full = -g_reg;
        nt_full = -tn_reg;
        // back-facing, grazing, or origin behind the plane
        reject3_next = !g_reg[GW-1] || (!tn_reg[TW-1] && (tn_reg != '0));
        lhs_ext  = RW'(lhs4_reg);
        rhs_ext  = RW'(rhs4_reg);
        ngsh_ext = RW'({ng3_reg, {D{1'b0}}});
        // best-distance product split in two halves
        rhs_hi   = ng3_reg[NGW-1:NLO] * best3_reg;
        rhs_lo   = ng3_reg[NLO-1:0] * best3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
            f4_reg <= '0;
            f5_reg <= '0;
        end else if (en) begin
            f1_reg <= '{valid: in_valid, reject: 1'b0, closer: 1'b0};
            f2_reg <= f1_reg;
            f3_reg <= '{valid: f2_reg.valid, reject: reject3_next, closer: 1'b0};
            f4_reg <= f3_reg;
            f5_reg <= '{valid:  f4_reg.valid,
                        reject: f4_reg.reject || (bv4_reg && (lhs_ext > rhs_ext)),
                        closer: bv4_reg && (lhs_ext < rhs_ext)};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nd_reg[i] <= $signed(normal[i*C +: C]) * $signed(in_dir[i*C +: C]);
                nv_reg[i] <= $signed(normal[i*C +: C]) * $signed(vert_a[i*C +: C]);
                no_reg[i] <= $signed(normal[i*C +: C]) * $signed(in_origin[i*C +: C]);
            end
            o1_reg    <= in_origin;
            d1_reg    <= in_dir;
            best1_reg <= in_best;
            bv1_reg   <= in_best_valid;

            g_reg     <= g_next;
            tn_reg    <= tn_next;
            o2_reg    <= o1_reg;
            d2_reg    <= d1_reg;
            best2_reg <= best1_reg;
            bv2_reg   <= bv1_reg;

            ng3_reg   <= ng_full[NGW-1:0];
            lhs3_reg  <= {nt_full[NTW-1:0], {F{1'b0}}};
            o3_reg    <= o2_reg;
            d3_reg    <= d2_reg;
            best3_reg <= best2_reg;
            bv3_reg   <= bv2_reg;

            rhs4_reg  <= {rhs_hi, {NLO{1'b0}}} + (NGW+D)'(rhs_lo);
            ovf4_reg  <= RW'(lhs3_reg) >= ngsh_ext;
            lhs4_reg  <= lhs3_reg;
            ng4_reg   <= ng3_reg;
            o4_reg    <= o3_reg;
            d4_reg    <= d3_reg;
            bv4_reg   <= bv3_reg;

            rem5_reg  <= lhs_ext;
            ng5_reg   <= ng4_reg;
            ovf5_reg  <= ovf4_reg;
            o5_reg    <= o4_reg;
            d5_reg    <= d4_reg;
        end
    end

    assign out_flags  = f5_reg;
    assign out_rem    = rem5_reg;
    assign out_ng     = ng5_reg;
    assign out_ovf    = ovf5_reg;
    assign out_origin = o5_reg;
    assign out_dir    = d5_reg;

endmodule

@@ hw/rtl/rti_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with
// saturation on overflow; carries ray data alongside; uses rti_pkg
module rti_div #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF,
    localparam int D   = COORD_BITS - 1,
    localparam int NGW = 2*COORD_BITS + 1,
    localparam int LW  = 2*COORD_BITS + 2 + FRAC_BITS,
    localparam int RW  = (LW > NGW + D) ? LW : NGW + D,
    localparam int SBW = 6*COORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  rti_pkg::rti_flags_t  in_flags,
    input  logic [RW-1:0]        in_rem,
    input  logic [NGW-1:0]       in_ng,
    input  logic                 in_ovf,
    input  logic [SBW-1:0]       in_side,
    output rti_pkg::rti_flags_t  out_flags,
    output logic [D-1:0]         out_tq,
    output logic [SBW-1:0]       out_side
);
    import rti_pkg::*;

    rti_flags_t flags_reg [D];
    logic [RW-1:0]  rem_reg  [D];
    logic [NGW-1:0] ng_reg   [D];
    logic           ovf_reg  [D];
    logic [D-1:0]   q_reg    [D];
    logic [SBW-1:0] side_reg [D];

    rti_flags_t st_flags [D];
    logic [RW-1:0]  st_rem  [D];
    logic [NGW-1:0] st_ng   [D];
    logic           st_ovf  [D];
    logic [D-1:0]   st_q    [D];
    logic [SBW-1:0] st_side [D];
    logic [RW-1:0]  trial    [D];
    logic [RW-1:0]  rem_next [D];
    logic [D-1:0]   q_next   [D];
    logic           ge       [D];

    always_comb begin
        st_flags[0] = in_flags;
        st_rem[0]   = in_rem;
        st_ng[0]    = in_ng;
        st_ovf[0]   = in_ovf;
        st_q[0]     = '0;
        st_side[0]  = in_side;
        for (int j = 1; j < D; j++) begin
            st_flags[j] = flags_reg[j-1];
            st_rem[j]   = rem_reg[j-1];
            st_ng[j]    = ng_reg[j-1];
            st_ovf[j]   = ovf_reg[j-1];
            st_q[j]     = q_reg[j-1];
            st_side[j]  = side_reg[j-1];
        end
        for (int j = 0; j < D; j++) begin
            trial[j]    = RW'(st_ng[j]) << (D - 1 - j);
            ge[j]       = st_rem[j] >= trial[j];
            rem_next[j] = ge[j] ? st_rem[j] - trial[j] : st_rem[j];
            q_next[j]   = st_q[j] | (D'(ge[j]) << (D - 1 - j));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < D; j++) begin
                flags_reg[j] <= '0;
            end
        end else if (en) begin
            for (int j = 0; j < D; j++) begin
                flags_reg[j] <= st_flags[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < D; j++) begin
                rem_reg[j]  <= rem_next[j];
                ng_reg[j]   <= st_ng[j];
                ovf_reg[j]  <= st_ovf[j];
                q_reg[j]    <= q_next[j];
                side_reg[j] <= st_side[j];
            end
        end
    end

    assign out_flags = flags_reg[D-1];
    assign out_tq    = ovf_reg[D-1] ? '1 : q_reg[D-1];
    assign out_side  = side_reg[D-1];

endmodule

@@ hw/rtl/rti_back.sv @@
// back pipeline: hit point, projected barycentric test and the
// output register; uses rti_pkg and values from rti_cfg
module rti_back #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF,
    localparam int D = COORD_BITS - 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  rti_pkg::rti_flags_t             in_flags,
    input  logic [D-1:0]                    in_tq,
    input  logic [6*COORD_BITS-1:0]         in_side,
    input  rti_pkg::plane_t                 plane,
    input  logic signed [COORD_BITS-1:0]    vaa,
    input  logic signed [COORD_BITS-1:0]    vab,
    input  logic signed [COORD_BITS:0]      u1,
    input  logic signed [COORD_BITS:0]      u2,
    input  logic signed [COORD_BITS:0]      v1,
    input  logic signed [COORD_BITS:0]      v2,
    input  logic signed [2*COORD_BITS+2:0]  den,
    output logic                            out_valid,
    output logic                            out_hit,
    output logic                            out_closer,
    output logic [D-1:0]                    out_dist,
    output logic [3*COORD_BITS-1:0]         out_point
);
    import rti_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int MW = C + D + 1;
    localparam int PW = ((MW - F > C) ? MW - F : C) + 1;
    localparam int UW = PW + 1;
    localparam int NW = UW + C + 1;
    localparam int AW = NW + 1;
    localparam int SW = AW + 1;
    localparam int DW = 2*C + 3;
    localparam logic signed [PW-1:0] CMAXV = PW'((2**(C-1)) - 1);
    localparam logic signed [PW-1:0] CMINV = ~CMAXV;

    rti_flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic [D-1:0] tq1_reg, tq2_reg, tq3_reg, tq4_reg, tq5_reg;
    logic [3*C-1:0] o1_reg;
    logic signed [MW-1:0] prod_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic [3*C-1:0] pc3_reg, pc4_reg, pc5_reg;
    logic signed [UW-1:0] u0_reg, v0_reg;
    logic signed [NW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [AW-1:0] na_reg, nb_reg;
    logic valid_reg, hit_reg, closer_reg;
    logic [D-1:0] dist_reg;
    logic [3*C-1:0] point_reg;

    logic signed [PW-1:0] pa, pb;
    logic [3*C-1:0] pc_next;
    logic signed [SW-1:0] sum_c, den_c;
    logic fail_c, hit_c;

    always_comb begin
        unique case (plane)
            PLANE_XZ: begin
                pa = p_reg[0];
                pb = p_reg[2];
            end
            PLANE_YZ: begin
                pa = p_reg[1];
                pb = p_reg[2];
            end
            default: begin
                pa = p_reg[0];
                pb = p_reg[1];
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            if (p_reg[i] > CMAXV) begin
                pc_next[i*C +: C] = CMAXV[C-1:0];
            end else if (p_reg[i] < CMINV) begin
                pc_next[i*C +: C] = CMINV[C-1:0];
            end else begin
                pc_next[i*C +: C] = p_reg[i][C-1:0];
            end
        end
    end

    always_comb begin
        sum_c = SW'(na_reg) + SW'(nb_reg);
        den_c = SW'(den);
        if (den == '0) begin
            fail_c = 1'b1;
        end else if (!den[DW-1]) begin
            fail_c = na_reg[AW-1] || nb_reg[AW-1] || (sum_c > den_c);
        end else begin
            fail_c = (!na_reg[AW-1] && (na_reg != '0))
                  || (!nb_reg[AW-1] && (nb_reg != '0)) || (sum_c < den_c);
        end
        hit_c = f5_reg.valid && !f5_reg.reject && !fail_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg    <= '0;
            f2_reg    <= '0;
            f3_reg    <= '0;
            f4_reg    <= '0;
            f5_reg    <= '0;
            valid_reg <= 1'b0;
        end else if (en) begin
            f1_reg    <= in_flags;
            f2_reg    <= f1_reg;
            f3_reg    <= f2_reg;
            f4_reg    <= f3_reg;
            f5_reg    <= f4_reg;
            valid_reg <= f5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= $signed(in_side[(3+i)*C +: C]) * $signed({1'b0, in_tq});
                p_reg[i]    <= PW'($signed(o1_reg[i*C +: C])) + PW'(prod_reg[i] >>> F);
            end
            o1_reg  <= in_side[3*C-1:0];
            tq1_reg <= in_tq;
            tq2_reg <= tq1_reg;

            u0_reg  <= UW'(pa) - UW'(vaa);
            v0_reg  <= UW'(pb) - UW'(vab);
            pc3_reg <= pc_next;
            tq3_reg <= tq2_reg;

            m1_reg  <= u0_reg * v2;
            m2_reg  <= v0_reg * u2;
            m3_reg  <= u1 * v0_reg;
            m4_reg  <= v1 * u0_reg;
            pc4_reg <= pc3_reg;
            tq4_reg <= tq3_reg;

            na_reg  <= AW'(m1_reg) - AW'(m2_reg);
            nb_reg  <= AW'(m3_reg) - AW'(m4_reg);
            pc5_reg <= pc4_reg;
            tq5_reg <= tq4_reg;

            hit_reg    <= hit_c;
            closer_reg <= hit_c && f5_reg.closer;
            dist_reg   <= hit_c ? tq5_reg : '0;
            point_reg  <= hit_c ? pc5_reg : '0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_hit    = hit_reg;
    assign out_closer = closer_reg;
    assign out_dist   = dist_reg;
    assign out_point  = point_reg;

endmodule

@@ hw/rtl/ray_triangle_intersect_unit.sv @@
// ray/triangle intersection unit, top level
// instantiates rti_cfg, rti_front, rti_div and rti_back; uses rti_pkg
//
// usage: write the three vertices and the unit normal through the cfg
// channel (index 0..3, x/y/z packed from bit 0) while no ray is in flight.
// rays enter on the s_ stream, one per cycle unless stalled; tdata holds origin x/y/z,
// direction x/y/z and the best distance, tuser holds the best-valid flag.
// each ray gives exactly one item on the m_ stream: tuser is {closer, hit},
// tdata is {point z, y, x, distance}, all zero on a miss.
// pipeline: 5 front stages, COORD_BITS-1 divider stages (one quotient bit
// each) and 6 back stages.
// throughput: one ray per cycle unless stalled, set by the fully pipelined divider.
// the derived plane and edge values follow a cfg write through the registers of rti_cfg.
// reset clears every valid bit and the triangle registers to zero.
// when the receiver stalls the whole pipeline holds, s_tready drops
// and nothing is lost or repeated.
module ray_triangle_intersect_unit #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF,
    localparam int SDW = ((7*COORD_BITS - 1 + 7) / 8) * 8,
    localparam int MDW = ((4*COORD_BITS - 1 + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z, best_distance
    input  logic [SDW-1:0]                 s_tdata,
    // best_valid
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit_distance, point_x, point_y, point_z
    output logic [MDW-1:0]                 m_tdata,
    // hit, closer
    output logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rti_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int D   = COORD_BITS - 1;
    localparam int NGW = 2*C + 1;
    localparam int LW  = 2*C + 2 + FRAC_BITS;
    localparam int RW  = (LW > NGW + D) ? LW : NGW + D;

    logic en;
    logic [3*C-1:0] vert_a, normal;
    plane_t plane;
    logic signed [C-1:0] vaa, vab;
    logic signed [C:0] u1, u2, v1, v2;
    logic signed [2*C+2:0] den;

    rti_flags_t fr_flags, dv_flags;
    logic [RW-1:0] fr_rem;
    logic [NGW-1:0] fr_ng;
    logic fr_ovf;
    logic [3*C-1:0] fr_origin, fr_dir;
    logic [D-1:0] dv_tq;
    logic [6*C-1:0] dv_side;

    logic out_hit, out_closer;
    logic [D-1:0] out_dist;
    logic [3*C-1:0] out_point;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rti_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vert_a    (vert_a),
        .normal    (normal),
        .plane     (plane),
        .vaa       (vaa),
        .vab       (vab),
        .u1        (u1),
        .u2        (u2),
        .v1        (v1),
        .v2        (v2),
        .den       (den)
    );

    rti_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_tvalid),
        .in_origin     (s_tdata[3*C-1:0]),
        .in_dir        (s_tdata[6*C-1:3*C]),
        .in_best       (s_tdata[6*C+D-1:6*C]),
        .in_best_valid (s_tuser[0]),
        .vert_a        (vert_a),
        .normal        (normal),
        .out_flags     (fr_flags),
        .out_rem       (fr_rem),
        .out_ng        (fr_ng),
        .out_ovf       (fr_ovf),
        .out_origin    (fr_origin),
        .out_dir       (fr_dir)
    );

    rti_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_flags  (fr_flags),
        .in_rem    (fr_rem),
        .in_ng     (fr_ng),
        .in_ovf    (fr_ovf),
        .in_side   ({fr_dir, fr_origin}),
        .out_flags (dv_flags),
        .out_tq    (dv_tq),
        .out_side  (dv_side)
    );

    rti_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_flags   (dv_flags),
        .in_tq      (dv_tq),
        .in_side    (dv_side),
        .plane      (plane),
        .vaa        (vaa),
        .vab        (vab),
        .u1         (u1),
        .u2         (u2),
        .v1         (v1),
        .v2         (v2),
        .den        (den),
        .out_valid  (m_tvalid),
        .out_hit    (out_hit),
        .out_closer (out_closer),
        .out_dist   (out_dist),
        .out_point  (out_point)
    );

    assign m_tdata = MDW'({out_point, out_dist});
    assign m_tuser = {out_closer, out_hit};

`ifndef SYNTHESIS
    a_closer_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || !m_tuser[1]))
        else $error("closer flagged without a hit");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss item carries nonzero data");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule

@@ tb/sv/tb_ray_triangle_intersect_unit.sv @@
// testbench for ray_triangle_intersect_unit: random and directed rays against
// configured triangles, checked item by item against an in-bench predictor
// depends on rti_pkg and ray_triangle_intersect_unit
`timescale 1ns / 1ps

module tb_ray_triangle_intersect_unit;
    import rti_pkg::*;

    localparam int  CB = 21;
    localparam int  FB = 10;
    localparam longint CMAX = (1 <<< (CB - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint unsigned DMAX = (1 <<< (CB - 1)) - 1;
    localparam int  LIMIT = 400000;
    localparam int  SETTLE = 40;

    typedef struct {
        logic signed [CB-1:0] o[3];
        logic signed [CB-1:0] d[3];
        logic [CB-2:0]        best;
        logic                 bv;
    } ray_t;

    typedef struct {
        logic                 hit;
        logic                 closer;
        logic [CB-2:0]        hit_dist;
        logic signed [CB-1:0] pt[3];
    } hit_t;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [151:0]  s_tdata = '0;
    logic [0:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [87:0]   m_tdata;
    logic [1:0]    m_tuser;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ray_t   ray_q[$];
    hit_t   hit_q[$];
    ray_t   cur_ray;
    longint tri_v[3][3];
    longint tri_n[3];
    int     send_idle = 0;
    int     recv_stall = 0;
    logic   rx_hold = 0;
    int     err_cnt = 0;
    int     cyc = 0;

    ray_triangle_intersect_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    function automatic longint clamp_c(longint x);
        if (x > CMAX) return CMAX;
        if (x < CMIN) return CMIN;
        return x;
    endfunction

    function automatic longint mag(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic hit_t trace_ray(ray_t r);
        longint o[3], d[3], p[3];
        longint g, tn, u0, u1, u2, v0, v1, v2, den, na, nb;
        longint unsigned nt, ng, lhs, rhs, tq;
        int a, b;
        hit_t h;
        h.hit = 0;
        h.closer = 0;
        h.hit_dist = '0;
        g = 0;
        tn = 0;
        for (int i = 0; i < 3; i++) begin
            h.pt[i] = '0;
            o[i] = longint'(r.o[i]);
            d[i] = longint'(r.d[i]);
            g += tri_n[i] * d[i];
            tn += tri_n[i] * (tri_v[0][i] - o[i]);
        end
        if (g >= 0 || tn > 0) return h;
        nt = -tn;
        ng = -g;
        lhs = nt << FB;
        rhs = ng * longint'(r.best);
        if (r.bv && lhs > rhs) return h;
        tq = lhs / ng;
        if (tq > DMAX) tq = DMAX;
        for (int i = 0; i < 3; i++) p[i] = o[i] + ((d[i] * longint'(tq)) >>> FB);
        if (mag(tri_n[0]) > mag(tri_n[1])) begin
            if (mag(tri_n[0]) > mag(tri_n[2])) begin a = 1; b = 2; end
            else begin a = 0; b = 1; end
        end else begin
            if (mag(tri_n[1]) > mag(tri_n[2])) begin a = 0; b = 2; end
            else begin a = 0; b = 1; end
        end
        u0 = p[a] - tri_v[0][a];
        u1 = tri_v[1][a] - tri_v[0][a];
        u2 = tri_v[2][a] - tri_v[0][a];
        v0 = p[b] - tri_v[0][b];
        v1 = tri_v[1][b] - tri_v[0][b];
        v2 = tri_v[2][b] - tri_v[0][b];
        den = u1 * v2 - v1 * u2;
        if (den == 0) return h;
        na = u0 * v2 - v0 * u2;
        nb = u1 * v0 - v1 * u0;
        if (den > 0 && (na < 0 || nb < 0 || na + nb > den)) return h;
        if (den < 0 && (na > 0 || nb > 0 || na + nb < den)) return h;
        h.hit = 1;
        h.closer = r.bv && lhs < rhs;
        h.hit_dist = tq[CB-2:0];
        for (int i = 0; i < 3; i++) h.pt[i] = CB'(clamp_c(p[i]));
        return h;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("error at cycle %0d: %s got %0h want %0h", cyc, what, got, want);
        err_cnt++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) hit_q.push_back(trace_ray(cur_ray));
            if (!s_tvalid || s_tready) begin
                if (ray_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_ray = ray_q.pop_front();
                    s_tdata <= {6'b0, cur_ray.best, cur_ray.d[2], cur_ray.d[1], cur_ray.d[0],
                                cur_ray.o[2], cur_ray.o[1], cur_ray.o[0]};
                    s_tuser <= cur_ray.bv;
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        hit_t w;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hit_q.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], 0);
                end else begin
                    w = hit_q.pop_front();
                    if (m_tuser[0] !== w.hit) report("hit", m_tuser[0], w.hit);
                    if (m_tuser[1] !== w.closer) report("closer", m_tuser[1], w.closer);
                    if (m_tdata[19:0] !== w.hit_dist)
                        report("hit_distance", m_tdata[19:0], w.hit_dist);
                    if (m_tdata[40:20] !== w.pt[0]) report("point_x", m_tdata[40:20], w.pt[0]);
                    if (m_tdata[61:41] !== w.pt[1]) report("point_y", m_tdata[61:41], w.pt[1]);
                    if (m_tdata[82:62] !== w.pt[2]) report("point_z", m_tdata[82:62], w.pt[2]);
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("ray_triangle_intersect_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [62:0] pack3(longint x, longint y, longint z);
        return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] val);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        for (int i = 0; i < 3; i++) begin
            if (idx == REG_NORMAL) tri_n[i] = signed'(val[i*CB +: CB]);
            else tri_v[idx][i] = signed'(val[i*CB +: CB]);
        end
    endtask

    task automatic set_triangle(input logic [62:0] a, b, c, n);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_NORMAL, n);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push_ray(input longint ox, oy, oz, dx, dy, dz,
                            input longint unsigned best, input logic bv);
        ray_t r;
        r.o[0] = CB'(ox); r.o[1] = CB'(oy); r.o[2] = CB'(oz);
        r.d[0] = CB'(dx); r.d[1] = CB'(dy); r.d[2] = CB'(dz);
        r.best = (CB-1)'(best);
        r.bv = bv;
        ray_q.push_back(r);
    endtask

    task automatic drain;
        while (ray_q.size() > 0 || s_tvalid || hit_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ray aimed at a random point of the current triangle, from the front side
    task automatic push_aimed;
        longint tgt[3], o[3], d[3];
        int r1, r2, m, sh;
        logic bv;
        longint unsigned best;
        r1 = $urandom_range(1024);
        r2 = $urandom_range(1024 - r1);
        m = $urandom_range(1, 8);
        sh = $urandom_range(3) == 0;
        for (int i = 0; i < 3; i++) begin
            tgt[i] = tri_v[0][i] + (((tri_v[1][i] - tri_v[0][i]) * r1
                     + (tri_v[2][i] - tri_v[0][i]) * r2) >>> FB);
            o[i] = clamp_c(tgt[i] + tri_n[i] * m + $signed($urandom_range(2048)) - 1024);
            d[i] = clamp_c((tgt[i] - o[i]) >>> sh);
        end
        bv = $urandom_range(1);
        best = (sh ? 2048 : 1024) + $urandom_range(16) - 8;
        if ($urandom_range(3) == 0) best = $urandom_range(DMAX);
        push_ray(o[0], o[1], o[2], d[0], d[1], d[2], best, bv);
    endtask

    task automatic push_noise;
        push_ray(signed'($urandom), signed'($urandom), signed'($urandom), signed'($urandom),
                 signed'($urandom), signed'($urandom), $urandom_range(DMAX), $urandom_range(1));
    endtask

    task automatic random_triangle(input int kind);
        longint v[3][3], e1[3], e2[3], n[3];
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) v[k][i] = longint'($urandom_range(131072)) - 65536;
        for (int i = 0; i < 3; i++) begin
            e1[i] = v[1][i] - v[0][i];
            e2[i] = v[2][i] - v[0][i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        while (mag(n[0]) >= 32768 || mag(n[1]) >= 32768 || mag(n[2]) >= 32768)
            for (int i = 0; i < 3; i++) n[i] = n[i] >>> 1;
        case (kind)
            1: begin n[0] = 1024; n[1] = 1024; n[2] = 1024; end
            2: begin n[0] = -1024; n[1] = 1024; n[2] = 0; end
            3: begin n[0] = 0; n[1] = 1024; n[2] = -1024; end
            4: begin n[0] = 1024; n[1] = 0; n[2] = 1024; end
            default: ;
        endcase
        set_triangle(pack3(v[0][0], v[0][1], v[0][2]), pack3(v[1][0], v[1][1], v[1][2]),
                     pack3(v[2][0], v[2][1], v[2][2]), pack3(n[0], n[1], n[2]));
    endtask

    initial begin
        for (int k = 0; k < 3; k++) begin
            tri_n[k] = 0;
            for (int i = 0; i < 3; i++) tri_v[k][i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        repeat (4) @(posedge aclk);

        // reset triangle: zero normal never hits
        push_ray(0, 0, 0, 0, 0, 0, 0, 0);
        push_ray(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, DMAX, 1);
        push_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 1);
        drain();

        set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(0, 4096, 0), pack3(0, 0, 1024));
        push_ray(1024, 1024, 2048, 0, 0, -1024, 0, 0);
        push_ray(1024, 1024, 2048, 0, 0, -1024, 2048, 1);
        push_ray(1024, 1024, 2048, 0, 0, -1024, 2049, 1);
        push_ray(1024, 1024, 2048, 0, 0, -1024, 2047, 1);
        push_ray(1024, 1024, 2048, 0, 0, 1024, 0, 0);
        push_ray(1024, 1024, 2048, 1024, 0, 0, 0, 0);
        push_ray(1024, 1024, -1024, 0, 0, -1024, 0, 0);
        push_ray(5120, 5120, 2048, 0, 0, -1024, 0, 0);
        push_ray(1024, 1024, CMAX, 0, 0, -1, 0, 0);
        push_ray(0, 0, 1024, 0, 0, -1024, 0, 0);
        push_ray(CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, DMAX, 1);
        drain();

        // collinear vertices
        set_triangle(pack3(0, 0, 0), pack3(4096, 0, 0), pack3(8192, 0, 0), pack3(0, 0, 1024));
        push_ray(1024, 0, 2048, 0, 0, -1024, 0, 0);
        push_ray(2048, 0, 1024, 0, 0, -512, 0, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 61; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 61; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            if (ph == 7) set_triangle('1, '1, '1, '1);
            else if (ph == 8) set_triangle({3{21'h100000}}, {3{21'h100000}},
                                           pack3(0, 0, 0), {3{21'h100000}});
            else random_triangle(ph % 5);
            if (ph == 4) begin
                fork
                    begin
                        @(posedge aclk);
                        rx_hold <= 1;
                        repeat (300) @(posedge aclk);
                        rx_hold <= 0;
                    end
                join_none
            end
            for (int j = 0; j < 40; j++) begin
                if ($urandom_range(4) == 0) push_noise();
                else push_aimed();
            end
            drain();
        end

        if (err_cnt == 0 && hit_q.size() == 0) begin
            $display("ray_triangle_intersect_unit: match");
        end else begin
            $display("ray_triangle_intersect_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rti_pkg.sv
hw/rtl/rti_cfg.sv
hw/rtl/rti_front.sv
hw/rtl/rti_div.sv
hw/rtl/rti_back.sv
hw/rtl/ray_triangle_intersect_unit.sv
tb/sv/tb_ray_triangle_intersect_unit.sv
